/* rtl/core/htfd_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// No dependencies; imported by every module of the block.
package htfd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // byte positions within a frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int OUT_DATA_W = 64;

    typedef struct packed {
        logic        status;
        logic [15:0] raw_temperature;
        logic [15:0] raw_humidity;
    } frame_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/core/htfd_front.sv */
// Front end: takes reply bytes, tracks frame position, runs the CRC checks
// and emits one frame record per complete frame. Depends on htfd_pkg.
module htfd_front
    import htfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       frame_restart,
    output logic       push,
    output frame_t     push_frame,
    input  logic       queue_full
);

    logic [2:0]  pos_reg,   pos_next;
    logic [7:0]  crc_reg,   crc_next;
    logic [7:0]  hold_reg,  hold_next;
    logic [15:0] tword_reg, tword_next;
    logic [15:0] hword_reg, hword_next;
    logic        fail_reg,  fail_next;
    logic [2:0]  pos_eff;
    logic        beat;
    logic        crc_bad;

    assign in_ready = !queue_full;
    assign beat     = in_valid && in_ready;
    assign crc_bad  = (crc_reg != rx_byte);

    always_comb
    begin
        pos_eff = pos_reg;
        if (frame_restart || pos_reg > POS_H_CRC)
            pos_eff = POS_T_HI;
    end

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        hold_next  = hold_reg;
        tword_next = tword_reg;
        hword_next = hword_reg;
        fail_next  = fail_reg;
        if (beat)
        begin
            pos_next = (pos_eff == POS_H_CRC) ? POS_T_HI : pos_eff + 3'd1;
            case (pos_eff)
                POS_T_HI:
                begin
                    fail_next = 1'b0;
                    crc_next  = crc8_byte(CRC_INIT, rx_byte);
                    hold_next = rx_byte;
                end
                POS_H_HI:
                begin
                    crc_next  = crc8_byte(CRC_INIT, rx_byte);
                    hold_next = rx_byte;
                end
                POS_T_LO:
                begin
                    crc_next   = crc8_byte(crc_reg, rx_byte);
                    tword_next = {hold_reg, rx_byte};
                end
                POS_H_LO:
                begin
                    crc_next   = crc8_byte(crc_reg, rx_byte);
                    hword_next = {hold_reg, rx_byte};
                end
                default:
                begin
                    if (crc_bad)
                        fail_next = 1'b1;
                    crc_next = CRC_INIT;
                end
            endcase
        end
    end

    assign push                       = beat && (pos_eff == POS_H_CRC);
    assign push_frame.status          = fail_reg || crc_bad;
    assign push_frame.raw_temperature = tword_reg;
    assign push_frame.raw_humidity    = hword_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_T_HI;
            crc_reg   <= CRC_INIT;
            hold_reg  <= '0;
            tword_reg <= '0;
            hword_reg <= '0;
            fail_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            hold_reg  <= hold_next;
            tword_reg <= tword_next;
            hword_reg <= hword_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

/* rtl/core/htfd_queue.sv */
// Short frame-record queue between front and back end.
// Depends on htfd_pkg.
module htfd_queue
    import htfd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_frame,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output frame_t head
);

    frame_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, wr_next;
    logic [QUEUE_AW-1:0] rd_reg, rd_next;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full      = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_reg];

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        return (p == (QUEUE_AW)'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_next  = do_push ? ptr_inc(wr_reg) : wr_reg;
        rd_next  = do_pop  ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/core/htfd_back.sv */
// Back end: scales the raw words (multiply stage, then divide-by-65535 stage)
// and holds the result in the output register. Depends on htfd_pkg.
module htfd_back
    import htfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  frame_t                head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    // multiply stage
    logic        s1_valid_reg, s1_valid_next;
    frame_t      s1_frame_reg;
    logic [30:0] s1_tprod_reg;
    logic [29:0] s1_hprod_reg;

    // output stage
    logic        out_valid_reg, out_valid_next;
    frame_t      out_frame_reg;
    logic [14:0] out_temp_reg, out_temp_next;
    logic [13:0] out_hum_reg,  out_hum_next;

    logic        out_load, s1_load;
    logic [14:0] tq0, tq;
    logic [13:0] hq0, hq;
    logic [16:0] tr, hr;
    logic [15:0] tdiff;

    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s1_load  = !s1_valid_reg || out_load;
    assign pop      = s1_load && head_valid;

    // floor(x/65535): q0 = x>>16, remainder q0 + low half, one correction
    always_comb
    begin
        tq0   = s1_tprod_reg[30:16];
        tr    = {1'b0, s1_tprod_reg[15:0]} + 17'(tq0);
        tq    = tq0 + 15'(tr >= 17'(FULL_SCALE));
        hq0   = s1_hprod_reg[29:16];
        hr    = {1'b0, s1_hprod_reg[15:0]} + 17'(hq0);
        hq    = hq0 + 14'(hr >= 17'(FULL_SCALE));
        tdiff = 16'(tq) - TEMP_OFFSET;
        out_temp_next = tdiff[14:0];
        out_hum_next  = hq;
    end

    always_comb
    begin
        s1_valid_next  = s1_load ? head_valid : s1_valid_reg;
        out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_frame_reg <= head;
            s1_tprod_reg <= 31'(head.raw_temperature) * 31'(TEMP_SPAN);
            s1_hprod_reg <= 30'(head.raw_humidity) * 30'(HUM_SPAN);
        end
        if (out_load)
        begin
            out_frame_reg <= s1_frame_reg;
            out_temp_reg  <= out_temp_next;
            out_hum_reg   <= out_hum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_frame_reg.status;
    assign m_tdata  = {3'b000, out_frame_reg.raw_humidity, out_frame_reg.raw_temperature,
                       out_hum_reg, out_temp_reg};

endmodule

/* rtl/core/humidity_temp_frame_decoder.sv */
// Top level of the humidity/temperature frame decoder.
// Depends on htfd_pkg, htfd_front, htfd_queue and htfd_back.
//
// Usage:
//   Input stream: one reply byte per beat on s_tdata; s_tuser high marks the
//   beat as byte zero of a new frame and drops any partial frame. Frame order
//   is temperature high, low, CRC, humidity high, low, CRC (CRC-8, poly 0x31,
//   init 0xFF). Every sixth byte closes a frame.
//   Output stream: one beat per frame on m_tdata, status on m_tuser
//   (1 = at least one CRC mismatch; words and scaled values still given).
//   Throughput: one byte per cycle while s_tready is high. Path: the beat
//   carrying the final CRC byte goes through the queue, then the multiply
//   stage, then divide-by-65535 into the output register, raising m_tvalid.
//   Stall: a held m_tready backs up the output register, multiply stage and
//   a two-entry frame queue; s_tready falls only when the queue is full.
//   Reset (rst_n low, asynchronous) empties the pipeline and returns the
//   decoder to byte zero with the CRC at 0xFF.
module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic                  s_tuser,   // [0] frame_restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [14:0] temperature_centi,
                                             // [28:15] humidity_centi,
                                             // [44:29] raw_temperature,
                                             // [60:45] raw_humidity, [63:61] zero
    output logic                  m_tuser    // [0] status
);

    logic   push, full, pop, not_empty;
    frame_t push_frame, head;

    htfd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .rx_byte       (s_tdata),
        .frame_restart (s_tuser),
        .push          (push),
        .push_frame    (push_frame),
        .queue_full    (full)
    );

    htfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    htfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
